// File: src/tpc_pkg.sv
// Package: beat types, command/status structs and helper functions for the plane clipper.
`default_nettype none
package tpc_pkg;

  localparam int unsigned NCOMP = 11;  // x y z, nx ny nz, tx ty tz, u v

  localparam logic [1:0] REG_SPLIT_AXIS     = 2'd0;
  localparam logic [1:0] REG_SPLIT_POSITION = 2'd1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic signed [15:0] tang_x;
    logic signed [15:0] tang_y;
    logic signed [15:0] tang_z;
    logic [31:0]        tex_uv;
  } in_beat_t;

  typedef struct packed {
    logic               out_side;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [15:0] out_nx;
    logic signed [15:0] out_ny;
    logic signed [15:0] out_nz;
    logic signed [15:0] out_tx;
    logic signed [15:0] out_ty;
    logic signed [15:0] out_tz;
    logic [31:0]        out_uv;
    logic               out_last;
  } out_beat_t;

  typedef logic signed [31:0] comp_t;
  typedef comp_t [NCOMP-1:0] vtx_t;

  // vertex slots: corners C0 to C2, edge crossings X0 and X1
  typedef enum logic [2:0] {
    VS_C0, VS_C1, VS_C2, VS_X0, VS_X1
  } vsel_e;

  typedef struct packed {
    logic       store_en;
    logic [1:0] store_slot;
    logic       dist_en;
    logic       div_load;
    logic       div_step;
    logic       div_first;
    logic       k_load;
    logic       ph0;
    logic       ph1;
    logic       ph2;
    logic       ph3;
    logic [3:0] comp;
    logic       xslot;
    logic [1:0] a_sel;
    logic [1:0] b_sel;
    logic       out_load;
    vsel_e      out_vsel;
    logic       out_side;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] left;
    logic       out_free;
  } sts_t;

  // emit order inside one side: 0 1 2 3 0 2
  function automatic logic [1:0] order_idx(input logic [2:0] p);
    logic [1:0] r;
    case (p)
      3'd0: r = 2'd0;
      3'd1: r = 2'd1;
      3'd2: r = 2'd2;
      3'd3: r = 2'd3;
      3'd4: r = 2'd0;
      3'd5: r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] side_count(input logic [2:0] n);
    logic [2:0] r;
    case (n)
      3'd3: r = 3'd3;
      3'd4: r = 3'd6;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic vtx_t to_vtx(input in_beat_t b);
    vtx_t v;
    v[0]  = b.pos_x;
    v[1]  = b.pos_y;
    v[2]  = b.pos_z;
    v[3]  = 32'(b.norm_x);
    v[4]  = 32'(b.norm_y);
    v[5]  = 32'(b.norm_z);
    v[6]  = 32'(b.tang_x);
    v[7]  = 32'(b.tang_y);
    v[8]  = 32'(b.tang_z);
    v[9]  = {{16{b.tex_uv[31]}}, b.tex_uv[31:16]};
    v[10] = {{16{b.tex_uv[15]}}, b.tex_uv[15:0]};
    return v;
  endfunction

  function automatic out_beat_t from_vtx(input vtx_t v, input logic side, input logic last);
    out_beat_t o;
    o.out_side = side;
    o.out_x    = v[0];
    o.out_y    = v[1];
    o.out_z    = v[2];
    o.out_nx   = v[3][15:0];
    o.out_ny   = v[4][15:0];
    o.out_nz   = v[5][15:0];
    o.out_tx   = v[6][15:0];
    o.out_ty   = v[7][15:0];
    o.out_tz   = v[8][15:0];
    o.out_uv   = {v[9][15:0], v[10][15:0]};
    o.out_last = last;
    return o;
  endfunction

endpackage
`default_nettype wire

// File: src/triangle_plane_clipper_top.sv
// Top level of the triangle plane clipper: controller plus datapath.
//
//  channel  direction  handshake               payload
//  cfg      in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//  in       in         in_valid_i/in_ready_o    in_beat_i (one vertex)
//  out      out        out_valid_o/out_ready_i  out_beat_o (one emitted vertex)
//
// Corners one and two are only stored and emit nothing. The third corner
// starts the clip: a distance step and a planning step, then per edge crossing
// a divider load, 32 divider steps, a ratio load and 11 components x 4 multiply
// phases, then one emitted vertex per cycle, 3 to 9 beats. The bit-serial divider
// and the shared split multiplier dominate this time. Output stalls hold the emit
// sequence; input is taken only while idle. Reset clears control, the plane
// registers and out valid; corner storage is always written before use.
`default_nettype none
module triangle_plane_clipper_top (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire [1:0]          cfg_index_i,
  input  wire [31:0]         cfg_data_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  tpc_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output tpc_pkg::out_beat_t out_beat_o
);

  tpc_pkg::cmd_t cmd;
  tpc_pkg::sts_t sts;

  // config writes land at once; the plane is sampled in the cycle after the third corner
  assign cfg_ready_o = 1'b1;

  tpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tpc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_beat_i   (in_beat_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
`default_nettype wire

// File: src/tpc_datapath.sv
// Datapath: corner store, distances, serial divider, split multiplier, output register.
`default_nettype none
module tpc_datapath (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_valid_i,
  input  wire [1:0]          cfg_index_i,
  input  wire [31:0]         cfg_data_i,
  input  tpc_pkg::in_beat_t  in_beat_i,
  input  tpc_pkg::cmd_t      cmd_i,
  output tpc_pkg::sts_t      sts_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output tpc_pkg::out_beat_t out_beat_o
);

  logic [1:0]         axis_q;
  logic signed [31:0] split_q;

  tpc_pkg::vtx_t c0_q, c1_q, c2_q, x0_q, x1_q;
  logic signed [32:0] d0_q, d1_q, d2_q;

  logic [33:0] rem_q;
  logic [32:0] dd_q;
  logic [31:0] quo_q;
  logic [30:0] k_q;

  logic [32:0] mag_q;
  logic        neg_q;
  logic signed [31:0] a_q;
  logic [47:0] phi_q;
  logic [63:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q  <= '0;
      split_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == tpc_pkg::REG_SPLIT_AXIS) axis_q <= cfg_data_i[1:0];
      else if (cfg_index_i == tpc_pkg::REG_SPLIT_POSITION) split_q <= cfg_data_i;
    end
  end

  function automatic tpc_pkg::vtx_t pick_corner(input logic [1:0] s, input tpc_pkg::vtx_t v0,
                                                input tpc_pkg::vtx_t v1, input tpc_pkg::vtx_t v2);
    tpc_pkg::vtx_t r;
    case (s)
      2'd0: r = v0;
      2'd1: r = v1;
      default: r = v2;
    endcase
    return r;
  endfunction

  function automatic logic signed [32:0] pick_dist(input logic [1:0] s, input logic signed [32:0] e0,
                                                   input logic signed [32:0] e1,
                                                   input logic signed [32:0] e2);
    logic signed [32:0] r;
    case (s)
      2'd0: r = e0;
      2'd1: r = e1;
      default: r = e2;
    endcase
    return r;
  endfunction

  function automatic logic signed [32:0] plane_dist(input tpc_pkg::vtx_t v, input logic [1:0] ax,
                                                    input logic signed [31:0] sp);
    logic signed [31:0] c;
    case (ax)
      tpc_pkg::AXIS_X: c = v[0];
      tpc_pkg::AXIS_Y: c = v[1];
      default:         c = v[2];  // z, also for code three
    endcase
    return 33'(c) - 33'(sp);
  endfunction

  tpc_pkg::vtx_t av, bv;
  logic signed [32:0] da, db;
  logic signed [33:0] dsub;
  logic [33:0] na, dda;
  logic [33:0] rtry;
  logic signed [32:0] cdiff;
  logic [46:0] plo;
  logic [63:0] acc_d;
  logic [32:0] rnd;
  logic signed [33:0] res;
  tpc_pkg::vtx_t vout;

  always_comb begin
    av    = pick_corner(cmd_i.a_sel, c0_q, c1_q, c2_q);
    bv    = pick_corner(cmd_i.b_sel, c0_q, c1_q, c2_q);
    da    = pick_dist(cmd_i.a_sel, d0_q, d1_q, d2_q);
    db    = pick_dist(cmd_i.b_sel, d0_q, d1_q, d2_q);
    dsub  = 34'(db) - 34'(da);
    na    = da[32] ? 34'(-34'(da)) : 34'(da);
    dda   = dsub[33] ? 34'(-dsub) : 34'(dsub);
    rtry  = cmd_i.div_first ? rem_q : {rem_q[32:0], 1'b0};
    cdiff = 33'(bv[cmd_i.comp]) - 33'(av[cmd_i.comp]);
    plo   = mag_q[15:0] * k_q;
    acc_d = 64'({phi_q, 16'd0}) + 64'(plo);
    rnd   = 33'((acc_q + 64'd536870912) >> 30);
    res   = neg_q ? 34'(a_q) - 34'(rnd) : 34'(a_q) + 34'(rnd);
    case (cmd_i.out_vsel)
      tpc_pkg::VS_C0: vout = c0_q;
      tpc_pkg::VS_C1: vout = c1_q;
      tpc_pkg::VS_C2: vout = c2_q;
      tpc_pkg::VS_X0: vout = x0_q;
      default:        vout = x1_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_en) begin
      case (cmd_i.store_slot)
        2'd0: c0_q <= tpc_pkg::to_vtx(in_beat_i);
        2'd1: c1_q <= tpc_pkg::to_vtx(in_beat_i);
        default: c2_q <= tpc_pkg::to_vtx(in_beat_i);
      endcase
    end
    if (cmd_i.dist_en) begin
      d0_q <= plane_dist(c0_q, axis_q, split_q);
      d1_q <= plane_dist(c1_q, axis_q, split_q);
      d2_q <= plane_dist(c2_q, axis_q, split_q);
    end
    if (cmd_i.div_load) begin
      rem_q <= na;
      dd_q  <= dda[32:0];
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rtry >= 34'(dd_q)) begin
        rem_q <= rtry - 34'(dd_q);
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rtry;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
    if (cmd_i.k_load) k_q <= 31'((33'(quo_q) + 33'd1) >> 1);
    if (cmd_i.ph0) begin
      neg_q <= cdiff[32];
      mag_q <= cdiff[32] ? 33'(-cdiff) : 33'(cdiff);
      a_q   <= av[cmd_i.comp];
    end
    if (cmd_i.ph1) phi_q <= mag_q[32:16] * k_q;
    if (cmd_i.ph2) acc_q <= acc_d;
    if (cmd_i.ph3) begin
      if (cmd_i.xslot) x1_q[cmd_i.comp] <= res[31:0];
      else x0_q[cmd_i.comp] <= res[31:0];
    end
    if (cmd_i.out_load) out_beat_o <= tpc_pkg::from_vtx(vout, cmd_i.out_side, cmd_i.out_last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  assign sts_o.left     = {(d2_q <= 0), (d1_q <= 0), (d0_q <= 0)};
  assign sts_o.out_free = !out_valid_o || out_ready_i;

endmodule
`default_nettype wire

// File: src/tpc_ctrl.sv
// Controller: corner count, clip planning, crossing sequencing and emit order.
`default_nettype none
module tpc_ctrl (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_ready_o,
  input  tpc_pkg::sts_t sts_i,
  output tpc_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIST, S_PLAN, S_DIVLD, S_DIV, S_KLD, S_M0, S_M1, S_M2, S_M3, S_EMIT
  } state_e;

  state_e state_q;
  logic [1:0] cc_q;
  logic [4:0] cnt_q;
  logic [3:0] comp_q;
  logic       xs_q;
  logic [1:0] nx_q;
  logic [2:0] nl_q, nr_q;
  tpc_pkg::vsel_e l_q [4];
  tpc_pkg::vsel_e r_q [4];
  logic [1:0] xa_q [2];
  logic [1:0] xb_q [2];
  logic       side_q;
  logic [2:0] pos_q;

  function automatic tpc_pkg::vsel_e corner(input logic [1:0] i);
    tpc_pkg::vsel_e r;
    case (i)
      2'd0: r = tpc_pkg::VS_C0;
      2'd1: r = tpc_pkg::VS_C1;
      default: r = tpc_pkg::VS_C2;
    endcase
    return r;
  endfunction

  // list building over the edges of the triangle
  tpc_pkg::vsel_e l_d [4];
  tpc_pkg::vsel_e r_d [4];
  logic [1:0] xa_d [2];
  logic [1:0] xb_d [2];
  logic [2:0] nl_d, nr_d;
  logic [1:0] nx_d;
  logic [1:0] jj;
  tpc_pkg::vsel_e xv;

  always_comb begin
    nl_d = '0; nr_d = '0; nx_d = '0; jj = '0; xv = tpc_pkg::VS_X0;
    for (int k = 0; k < 4; k++) begin
      l_d[k] = tpc_pkg::VS_C0;
      r_d[k] = tpc_pkg::VS_C0;
    end
    for (int k = 0; k < 2; k++) begin
      xa_d[k] = '0;
      xb_d[k] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      jj = (i == 2) ? 2'd0 : 2'(i + 1);
      if (sts_i.left[i]) begin
        l_d[nl_d[1:0]] = corner(2'(i));
        nl_d = nl_d + 3'd1;
      end else begin
        r_d[nr_d[1:0]] = corner(2'(i));
        nr_d = nr_d + 3'd1;
      end
      if (sts_i.left[i] != sts_i.left[jj]) begin
        xv = nx_d[0] ? tpc_pkg::VS_X1 : tpc_pkg::VS_X0;
        xa_d[nx_d[0]] = 2'(i);
        xb_d[nx_d[0]] = jj;
        if (nl_d < 3'd4) begin
          l_d[nl_d[1:0]] = xv;
          nl_d = nl_d + 3'd1;
        end
        if (nr_d < 3'd4) begin
          r_d[nr_d[1:0]] = xv;
          nr_d = nr_d + 3'd1;
        end
        nx_d = nx_d + 2'd1;
      end
    end
  end

  logic [2:0] cnt_l, cnt_r, cnt_cur;
  logic [1:0] oidx;
  logic       last_now;

  always_comb begin
    cnt_l    = tpc_pkg::side_count(nl_q);
    cnt_r    = tpc_pkg::side_count(nr_q);
    cnt_cur  = side_q ? cnt_r : cnt_l;
    oidx     = tpc_pkg::order_idx(pos_q);
    last_now = (pos_q == cnt_cur - 3'd1) && (side_q || cnt_r == 3'd0);
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.out_vsel   = side_q ? r_q[oidx] : l_q[oidx];
    cmd_o.out_side   = side_q;
    cmd_o.out_last   = last_now;
    cmd_o.store_slot = cc_q;
    cmd_o.comp       = comp_q;
    cmd_o.xslot      = xs_q;
    cmd_o.a_sel      = xa_q[xs_q];
    cmd_o.b_sel      = xb_q[xs_q];
    cmd_o.div_first  = (cnt_q == 5'd0);
    in_ready_o       = (state_q == S_IDLE);
    cmd_o.store_en   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.dist_en    = (state_q == S_DIST);
    cmd_o.div_load   = (state_q == S_DIVLD);
    cmd_o.div_step   = (state_q == S_DIV);
    cmd_o.k_load     = (state_q == S_KLD);
    cmd_o.ph0        = (state_q == S_M0);
    cmd_o.ph1        = (state_q == S_M1);
    cmd_o.ph2        = (state_q == S_M2);
    cmd_o.ph3        = (state_q == S_M3);
    cmd_o.out_load   = (state_q == S_EMIT) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cc_q    <= '0;
      cnt_q   <= '0;
      comp_q  <= '0;
      xs_q    <= 1'b0;
      nx_q    <= '0;
      nl_q    <= '0;
      nr_q    <= '0;
      side_q  <= 1'b0;
      pos_q   <= '0;
      for (int k = 0; k < 4; k++) begin
        l_q[k] <= tpc_pkg::VS_C0;
        r_q[k] <= tpc_pkg::VS_C0;
      end
      for (int k = 0; k < 2; k++) begin
        xa_q[k] <= '0;
        xb_q[k] <= '0;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (cc_q == 2'd2) begin
              cc_q    <= '0;
              state_q <= S_DIST;
            end else begin
              cc_q <= cc_q + 2'd1;
            end
          end
        end
        S_DIST: state_q <= S_PLAN;
        S_PLAN: begin
          l_q  <= l_d;
          r_q  <= r_d;
          xa_q <= xa_d;
          xb_q <= xb_d;
          nl_q <= nl_d;
          nr_q <= nr_d;
          nx_q <= nx_d;
          xs_q <= 1'b0;
          side_q <= (tpc_pkg::side_count(nl_d) == 3'd0);
          pos_q  <= '0;
          state_q <= (nx_d != 2'd0) ? S_DIVLD : S_EMIT;
        end
        S_DIVLD: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) state_q <= S_KLD;
        end
        S_KLD: begin
          comp_q  <= '0;
          state_q <= S_M0;
        end
        S_M0: state_q <= S_M1;
        S_M1: state_q <= S_M2;
        S_M2: state_q <= S_M3;
        S_M3: begin
          if (comp_q == 4'(tpc_pkg::NCOMP - 1)) begin
            if (2'(xs_q) == nx_q - 2'd1) begin
              state_q <= S_EMIT;
            end else begin
              xs_q    <= 1'b1;
              state_q <= S_DIVLD;
            end
          end else begin
            comp_q  <= comp_q + 4'd1;
            state_q <= S_M0;
          end
        end
        S_EMIT: begin
          if (sts_i.out_free) begin
            if (last_now) begin
              state_q <= S_IDLE;
            end else if (pos_q == cnt_cur - 3'd1) begin
              side_q <= 1'b1;
              pos_q  <= '0;
            end else begin
              pos_q <= pos_q + 3'd1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sim/tb_triangle_plane_clipper_top.sv
// Testbench for the triangle plane clipper: queued stimulus, clipping predictor, beat checker.
`timescale 1ns / 100ps
module tb_triangle_plane_clipper_top;
  import tpc_pkg::*;

  localparam int unsigned QUIET_CYCLES = 20;    // block idle time before a register write
  localparam int unsigned STALL_LIMIT  = 4000;  // cycles with no transfer on any channel
  localparam int unsigned TAIL_CYCLES  = 300;   // covers two full crossings plus emit

  typedef enum logic [1:0] {OP_VTX, OP_CFG, OP_DRAIN} op_kind_e;

  typedef struct {
    op_kind_e    kind;
    in_beat_t    vtx;
    logic [1:0]  idx;
    logic [31:0] data;
  } op_t;

  typedef longint corner_t [0:10];  // x y z nx ny nz tx ty tz u v, sign-extended

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  in_beat_t    in_beat_i = '0;
  logic        out_ready_i = 1'b0;
  logic        cfg_ready_o, in_ready_o, out_valid_o;
  out_beat_t   out_beat_o;

  triangle_plane_clipper_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stimulus script and predicted output beats
  op_t       stim_ops[$];
  out_beat_t clip_beats[$];

  // predictor's copy of the plane and the held corners
  logic [1:0]  plane_axis = AXIS_X;
  logic [31:0] plane_pos = '0;
  in_beat_t    held_corner[2];
  int unsigned corners_held = 0;

  int unsigned n_vtx = 0, n_tri = 0, n_cfg = 0, n_beats = 0, n_err = 0;

  // ---------------------------------------------------------------- predictor

  function automatic corner_t unpack_corner(in_beat_t b);
    corner_t c;
    c[0] = longint'(b.pos_x);
    c[1] = longint'(b.pos_y);
    c[2] = longint'(b.pos_z);
    c[3] = longint'(b.norm_x);
    c[4] = longint'(b.norm_y);
    c[5] = longint'(b.norm_z);
    c[6] = longint'(b.tang_x);
    c[7] = longint'(b.tang_y);
    c[8] = longint'(b.tang_z);
    c[9] = longint'($signed(b.tex_uv[31:16]));
    c[10] = longint'($signed(b.tex_uv[15:0]));
    return c;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // a + (b-a)*k, k in Q0.30, rounded half away from zero
  function automatic longint blend(longint a, longint b, longint unsigned k);
    longint unsigned r;
    r = (magnitude(b - a) * k + (64'd1 << 29)) >> 30;
    return (b < a) ? a - longint'(r) : a + longint'(r);
  endfunction

  function automatic corner_t edge_cut(corner_t a, corner_t b, longint da, longint db);
    corner_t w;
    longint unsigned k;
    k = (((magnitude(da) << 31) / magnitude(db - da)) + 1) >> 1;
    for (int i = 0; i < 11; i++) w[i] = blend(a[i], b[i], k);
    return w;
  endfunction

  function automatic out_beat_t pack_corner(corner_t c, logic side);
    out_beat_t o;
    o.out_side = side;
    o.out_x = c[0][31:0];
    o.out_y = c[1][31:0];
    o.out_z = c[2][31:0];
    o.out_nx = c[3][15:0];
    o.out_ny = c[4][15:0];
    o.out_nz = c[5][15:0];
    o.out_tx = c[6][15:0];
    o.out_ty = c[7][15:0];
    o.out_tz = c[8][15:0];
    o.out_uv = {c[9][15:0], c[10][15:0]};
    o.out_last = 1'b0;
    return o;
  endfunction

  // Takes one accepted vertex; on every third one clips the triangle and queues its beats.
  function automatic void clip_vertex(in_beat_t b);
    corner_t   tri_c[3];
    corner_t   lhs[4], rhs[4];
    longint    dists[3];
    int        nl, nr, ax, j, cnt;
    bit        cl, nxl;
    out_beat_t tri_beats[$];
    int        order[6] = '{0, 1, 2, 3, 0, 2};
    if (corners_held < 2) begin
      held_corner[corners_held] = b;
      corners_held++;
      return;
    end
    corners_held = 0;
    n_tri++;
    nl = 0;
    nr = 0;
    ax = (plane_axis == AXIS_X) ? 0 : (plane_axis == AXIS_Y) ? 1 : 2;  // code three acts as z
    tri_c[0] = unpack_corner(held_corner[0]);
    tri_c[1] = unpack_corner(held_corner[1]);
    tri_c[2] = unpack_corner(b);
    for (int i = 0; i < 3; i++) dists[i] = tri_c[i][ax] - longint'($signed(plane_pos));
    for (int i = 0; i < 3; i++) begin
      j = (i == 2) ? 0 : i + 1;
      cl = dists[i] <= 0;
      nxl = dists[j] <= 0;
      if (cl) lhs[nl++] = tri_c[i];
      else rhs[nr++] = tri_c[i];
      if (cl != nxl) begin
        corner_t w;
        w = edge_cut(tri_c[i], tri_c[j], dists[i], dists[j]);
        if (nl < 4) lhs[nl++] = w;
        if (nr < 4) rhs[nr++] = w;
      end
    end
    cnt = (nl == 3) ? 3 : (nl == 4) ? 6 : 0;
    for (int i = 0; i < cnt; i++) tri_beats.push_back(pack_corner(lhs[order[i]], 1'b0));
    cnt = (nr == 3) ? 3 : (nr == 4) ? 6 : 0;
    for (int i = 0; i < cnt; i++) tri_beats.push_back(pack_corner(rhs[order[i]], 1'b1));
    if (tri_beats.size() > 0) tri_beats[tri_beats.size() - 1].out_last = 1'b1;
    foreach (tri_beats[i]) clip_beats.push_back(tri_beats[i]);
  endfunction

  // ------------------------------------------------------------------- driver

  int unsigned burst_left = 1, gap_left = 0, quiet = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    bit       acc_in, acc_cfg, nxt_in_v, nxt_cfg_v, drained;
    in_beat_t nxt_beat;
    op_t      op;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      acc_in = in_valid_i && in_ready_o;
      acc_cfg = cfg_valid_i && cfg_ready_o;
      if (acc_in) begin
        clip_vertex(in_beat_i);
        n_vtx++;
      end
      if (acc_cfg) begin
        n_cfg++;
        if (cfg_index_i == REG_SPLIT_AXIS) plane_axis = cfg_data_i[1:0];
        else if (cfg_index_i == REG_SPLIT_POSITION) plane_pos = cfg_data_i;
      end
      nxt_in_v = in_valid_i && !acc_in;
      nxt_cfg_v = cfg_valid_i && !acc_cfg;
      nxt_beat = in_beat_i;
      // quiet counts idle cycles with nothing owed, so a partial triangle has settled too
      if (clip_beats.size() == 0 && !in_valid_i && !cfg_valid_i) quiet++;
      else quiet = 0;
      drained = quiet >= QUIET_CYCLES;
      if (!nxt_in_v && !nxt_cfg_v && stim_ops.size() > 0) begin
        op = stim_ops[0];
        if (op.kind == OP_VTX) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            void'(stim_ops.pop_front());
            nxt_in_v = 1'b1;
            nxt_beat = op.vtx;
            if (--burst_left == 0) begin
              burst_left = $urandom_range(1, 24);
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            end
          end
        end else if (drained) begin
          void'(stim_ops.pop_front());
          quiet = 0;
          if (op.kind == OP_CFG) begin
            nxt_cfg_v = 1'b1;
            cfg_index_i <= op.idx;
            cfg_data_i <= op.data;
          end
        end
      end
      in_valid_i <= nxt_in_v;
      in_beat_i <= nxt_beat;
      cfg_valid_i <= nxt_cfg_v;
    end
  end

  // ----------------------------------------------------------------- receiver
  // Stall pattern is redrawn at random from four modes; twice it holds off long enough to back up the input.

  int unsigned rx_cyc = 0, rx_mode = 0, hold_left = 0, holds_done = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      rx_cyc++;
      if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left == 0 && ((holds_done == 0 && n_beats >= 40) ||
                             (holds_done == 1 && n_beats >= 400))) begin
        hold_left = 700;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= (rx_cyc % 5) != 0;
          default: out_ready_i <= $urandom_range(0, 7) == 0;
        endcase
      end
    end
  end

  // ------------------------------------------------------------------ monitor

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_err++;
    end
  endtask

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_beats++;
      if (clip_beats.size() == 0) begin
        $error("unexpected output beat %p", out_beat_o);
        n_err++;
      end else begin
        want = clip_beats.pop_front();
        check_field("out_side", want.out_side, out_beat_o.out_side);
        check_field("out_x", want.out_x, out_beat_o.out_x);
        check_field("out_y", want.out_y, out_beat_o.out_y);
        check_field("out_z", want.out_z, out_beat_o.out_z);
        check_field("out_nx", want.out_nx, out_beat_o.out_nx);
        check_field("out_ny", want.out_ny, out_beat_o.out_ny);
        check_field("out_nz", want.out_nz, out_beat_o.out_nz);
        check_field("out_tx", want.out_tx, out_beat_o.out_tx);
        check_field("out_ty", want.out_ty, out_beat_o.out_ty);
        check_field("out_tz", want.out_tz, out_beat_o.out_tz);
        check_field("out_uv", want.out_uv, out_beat_o.out_uv);
        check_field("out_last", want.out_last, out_beat_o.out_last);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  logic [1:0]  gen_axis = AXIS_X;  // plane the generator aims at
  logic [31:0] gen_pos = '0;

  function automatic in_beat_t random_vertex();
    in_beat_t b;
    b.pos_x = $urandom;
    b.pos_y = $urandom;
    b.pos_z = $urandom;
    b.norm_x = 16'($urandom);
    b.norm_y = 16'($urandom);
    b.norm_z = 16'($urandom);
    b.tang_x = 16'($urandom);
    b.tang_y = 16'($urandom);
    b.tang_z = 16'($urandom);
    b.tex_uv = $urandom;
    return b;
  endfunction

  // vertex whose plane-axis coordinate sits at distance off from the plane (saturated)
  function automatic in_beat_t vertex_at(longint off);
    in_beat_t b;
    longint   c;
    b = random_vertex();
    c = longint'($signed(gen_pos)) + off;
    if (c > 64'sd2147483647) c = 64'sd2147483647;
    if (c < -64'sd2147483648) c = -64'sd2147483648;
    case (gen_axis)
      AXIS_X: b.pos_x = c[31:0];
      AXIS_Y: b.pos_y = c[31:0];
      default: b.pos_z = c[31:0];
    endcase
    return b;
  endfunction

  task automatic add_vtx(in_beat_t b);
    stim_ops.push_back('{kind: OP_VTX, vtx: b, idx: '0, data: '0});
  endtask

  task automatic add_cfg(logic [1:0] idx, logic [31:0] data);
    stim_ops.push_back('{kind: OP_CFG, vtx: '0, idx: idx, data: data});
    if (idx == REG_SPLIT_AXIS) gen_axis = data[1:0];
    else if (idx == REG_SPLIT_POSITION) gen_pos = data;
  endtask

  task automatic add_tri(longint d0, longint d1, longint d2);
    add_vtx(vertex_at(d0));
    add_vtx(vertex_at(d1));
    add_vtx(vertex_at(d2));
  endtask

  // offset near the plane, mostly small so edges cross often
  function automatic longint near_off();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return longint'($signed($urandom)) * 2;
      2: return longint'($urandom_range(0, 8)) - 4;
      default: return longint'($urandom_range(0, 400000)) - 200000;
    endcase
  endfunction

  initial begin
    in_beat_t    xb[3];
    int unsigned stall;
    int unsigned n_rand;

    // directed: plane x = 0, every split shape and the on-plane corner
    add_cfg(REG_SPLIT_AXIS, AXIS_X);
    add_cfg(REG_SPLIT_POSITION, 32'h0);
    add_tri(-5, 0, -70000);          // all left, one corner on the plane
    add_tri(3, 90000, 1);            // all right
    add_tri(-65536, 131072, 65536);  // one left, two right
    add_tri(-100, -200, 300);        // two left, one right
    add_tri(0, 5, -5);               // on-plane corner next to a crossing
    // field extremes; the plane at x = 0 splits the triangle
    xb[0] = '{pos_x: 32'h7fffffff, pos_y: 32'h80000000, pos_z: 32'h7fffffff,
              norm_x: 16'h7fff, norm_y: 16'h8000, norm_z: 16'h7fff,
              tang_x: 16'h8000, tang_y: 16'h7fff, tang_z: 16'h8000, tex_uv: 32'hffffffff};
    xb[1] = '{pos_x: 32'h80000000, pos_y: 32'h7fffffff, pos_z: 32'h80000000,
              norm_x: 16'h8000, norm_y: 16'h7fff, norm_z: 16'h8000,
              tang_x: 16'h7fff, tang_y: 16'h8000, tang_z: 16'h7fff, tex_uv: 32'h0};
    xb[2] = '{pos_x: 32'h0, pos_y: 32'hffffffff, pos_z: 32'h1,
              norm_x: 16'h0, norm_y: 16'hffff, norm_z: 16'h1,
              tang_x: 16'h0, tang_y: 16'hffff, tang_z: 16'h1, tex_uv: 32'h80007fff};
    for (int i = 0; i < 3; i++) add_vtx(xb[i]);       // widest crossings on x
    add_cfg(REG_SPLIT_AXIS, 2'd3);                      // code three behaves as z
    add_cfg(REG_SPLIT_POSITION, 32'h80000000);
    for (int i = 0; i < 3; i++) add_vtx(xb[i]);
    add_cfg(2'd2, $urandom);                            // unused index, ignored
    add_cfg(2'd3, $urandom);
    add_cfg(REG_SPLIT_AXIS, AXIS_Y);
    add_cfg(REG_SPLIT_POSITION, 32'h7fffffff);
    add_tri(0, -1, -3);
    // plane moved between corners: the one in force at the third corner counts
    add_cfg(REG_SPLIT_POSITION, 32'h0);
    add_tri(-1000, 2000, 0);
    void'(stim_ops.pop_back());
    add_cfg(REG_SPLIT_POSITION, 32'h00010000);
    add_vtx(vertex_at(-3000));

    // random: vertices mostly near the plane, plane changes, sender pauses
    n_rand = 0;
    while (n_rand < 460) begin
      if (n_rand % 60 == 0) begin
        add_cfg(REG_SPLIT_AXIS, $urandom_range(0, 3));
        case ($urandom_range(0, 4))
          0: add_cfg(REG_SPLIT_POSITION, 32'h7fffffff);
          1: add_cfg(REG_SPLIT_POSITION, 32'h80000000);
          2: add_cfg(REG_SPLIT_POSITION, $urandom);
          default: add_cfg(REG_SPLIT_POSITION, $urandom_range(0, 2000000) - 1000000);
        endcase
        if ($urandom_range(0, 2) == 0) add_cfg(2'($urandom_range(2, 3)), $urandom);
      end
      if (n_rand % 97 == 50) stim_ops.push_back('{kind: OP_DRAIN, vtx: '0, idx: '0, data: '0});
      if ($urandom_range(0, 9) == 0) add_vtx(random_vertex());
      else add_vtx(vertex_at(near_off()));
      n_rand++;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for the script to run dry and every beat to come back
    stall = 0;
    while (stim_ops.size() > 0 || in_valid_i || cfg_valid_i || clip_beats.size() > 0) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o) ||
          (out_valid_o && out_ready_i)) stall = 0;
      else stall++;
      if (stall >= STALL_LIMIT) begin
        $display("timeout: %0d beats still owed", clip_beats.size());
        $display("Test completed with failures");
        $finish;
      end
    end
    // extra beats during the tail are flagged by the monitor
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d vertices, %0d triangles, %0d output beats, %0d register writes",
             n_vtx, n_tri, n_beats, n_cfg);
    $display("splits on all axes incl. code three, plane at both extremes, long output stalls");
    if (n_err == 0 && clip_beats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
src/tpc_pkg.sv
src/tpc_datapath.sv
src/tpc_ctrl.sv
src/triangle_plane_clipper_top.sv
sim/tb_triangle_plane_clipper_top.sv
